[hdl/stet_pkg.sv]
// shared types, constants and register codes for the slope threshold edge trigger
package stet_pkg;

  localparam int unsigned DefDelayDepth = 256;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SlopeW  = 17;
  localparam int unsigned WinW    = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 17;

  localparam logic [WinW-1:0]    WinReset      = 9'd44;
  localparam logic [SampleW-1:0] SampleResetVal = 16'h8000;

  localparam logic [CfgIdxW-1:0] RegThreshold      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWindowLength   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEnableCombined = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEnableRise     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEnableFall     = 3'd4;

  typedef struct packed {
    logic signed [SlopeW-1:0] threshold;
    logic                     en_combined;
    logic                     en_rise;
    logic                     en_fall;
  } trig_cfg_t;

  typedef struct packed {
    logic combined;
    logic rise;
    logic fall;
  } fire_t;

endpackage

[hdl/stet_delay_mem.sv]
// delay line memory with write pointer, read address generation and fill tracking
module stet_delay_mem #(
  parameter int unsigned DELAY_DEPTH = stet_pkg::DefDelayDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [stet_pkg::SampleW-1:0]      wr_data_i,
  input  logic [stet_pkg::WinW-1:0]         win_len_i,
  output logic [stet_pkg::SampleW-1:0]      rd_data_o,
  output logic                              rd_written_o
);

  localparam int unsigned AW  = $clog2(DELAY_DEPTH);
  localparam int unsigned CW  = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned EW  = ((CW > stet_pkg::WinW) ? CW : stet_pkg::WinW) + 1;
  localparam logic [EW-1:0] DepthE = EW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DELAY_DEPTH - 1);

  logic [stet_pkg::SampleW-1:0] mem [DELAY_DEPTH];
  logic [stet_pkg::SampleW-1:0] rd_data_q;
  logic [AW-1:0] wp_q, wp_d;
  logic          wrapped_q, wrapped_d;
  logic          written_q, written_d;
  logic [EW-1:0] wl_raw, wl_c, wp_e, rd_e;
  logic [AW-1:0] rd_addr;

  always_comb begin
    wl_raw = EW'(win_len_i);
    if (wl_raw == '0) begin
      wl_c = EW'(1);
    end else if (wl_raw > DepthE) begin
      wl_c = DepthE;
    end else begin
      wl_c = wl_raw;
    end
    wp_e = EW'(wp_q);
    if (wp_e >= wl_c) begin
      rd_e = wp_e - wl_c;
    end else begin
      rd_e = wp_e + DepthE - wl_c;
    end
    rd_addr   = rd_e[AW-1:0];
    wp_d      = (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
    wrapped_d = wrapped_q | (wp_q == LastAddr);
    written_d = wrapped_q | (rd_addr < wp_q);
  end

  // read before write: with the longest window the read and write hit the same entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_data_q   <= mem[rd_addr];
      mem[wp_q]   <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      written_q <= 1'b0;
    end else if (en_i) begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      written_q <= written_d;
    end
  end

  assign rd_data_o    = rd_data_q;
  assign rd_written_o = written_q;

endmodule

[hdl/stet_slope_unit.sv]
// slope subtraction, previous slope state and threshold crossing comparisons
module stet_slope_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic [stet_pkg::SampleW-1:0]        sample_i,
  input  logic [stet_pkg::SampleW-1:0]        delayed_i,
  input  logic                                delayed_written_i,
  input  stet_pkg::trig_cfg_t                 cfg_i,
  output logic signed [stet_pkg::SlopeW-1:0]  slope_o,
  output stet_pkg::fire_t                     fire_o,
  output logic                                prev_valid_o
);

  localparam int unsigned CmpW = stet_pkg::SlopeW + 1;

  logic signed [stet_pkg::SlopeW-1:0] prev_slope_q;
  logic                               prev_valid_q;
  logic [stet_pkg::SampleW-1:0]       base;
  logic signed [stet_pkg::SlopeW-1:0] slope;
  logic signed [CmpW-1:0]             s_e, p_e, th_e, nth_e;

  always_comb begin
    base   = delayed_written_i ? delayed_i : stet_pkg::SampleResetVal;
    slope  = $signed({sample_i[stet_pkg::SampleW-1], sample_i})
           - $signed({base[stet_pkg::SampleW-1], base});
    s_e    = CmpW'(slope);
    p_e    = CmpW'(prev_slope_q);
    th_e   = CmpW'(cfg_i.threshold);
    nth_e  = -th_e;
    fire_o.combined = prev_valid_q && cfg_i.en_combined &&
                      (((th_e > 0) && (s_e > th_e) && (p_e < th_e)) ||
                       ((th_e < 0) && (s_e < th_e) && (p_e > th_e)));
    fire_o.rise     = prev_valid_q && cfg_i.en_rise && (s_e > th_e) && (p_e < th_e);
    fire_o.fall     = prev_valid_q && cfg_i.en_fall && (s_e < nth_e) && (p_e > nth_e);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_slope_q <= '0;
      prev_valid_q <= 1'b0;
    end else if (adv_i) begin
      prev_slope_q <= slope;
      prev_valid_q <= 1'b1;
    end
  end

  assign slope_o      = slope;
  assign prev_valid_o = prev_valid_q;

endmodule

[hdl/slope_threshold_edge_trigger.sv]
// top level of the slope threshold edge trigger
// Usage:
// - input channel in_valid_i / in_stall_o carries one signed sample_i per transfer
// - output channel out_valid_o / out_stall_i gives slope_o and three fire flags,
//   exactly one result per input transfer, in order
// - slope_o is the sample minus the sample window_length transfers earlier
// - configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
//   index 0 threshold, 1 window_length, 2..4 the combined, rise and fall enables;
//   write only while the block is idle, other indices are ignored
// - path: an accepted sample is registered in s1_sample_q, and its slope and
//   fire flags are registered in the output register behind out_valid_o
// - throughput: one sample per cycle while the output is not stalled, set by
//   one memory read and write per sample and the slope and compare stage
// - reset: delay line reads as -32768 until written, no previous slope,
//   threshold 0, window_length 44, all enables off; no clearing pass is needed
// - when the receiver stalls the result is held in the output register while a
//   second sample still enters the compare stage; further input then stalls
module slope_threshold_edge_trigger #(
  parameter int unsigned DELAY_DEPTH = stet_pkg::DefDelayDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [stet_pkg::SampleW-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [stet_pkg::SlopeW-1:0]  slope_o,
  output logic                                combined_fire_o,
  output logic                                rise_fire_o,
  output logic                                fall_fire_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stet_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [stet_pkg::CfgW-1:0]           cfg_data_i
);

  stet_pkg::trig_cfg_t          cfg_q;
  logic [stet_pkg::WinW-1:0]    win_len_q;
  logic                         cfg_we;

  logic                         s1_valid_q;
  logic [stet_pkg::SampleW-1:0] s1_sample_q;
  logic                         out_valid_q;
  logic signed [stet_pkg::SlopeW-1:0] out_slope_q;
  stet_pkg::fire_t              out_fire_q;

  logic                         out_free, s1_adv, in_acc;
  logic [stet_pkg::SampleW-1:0] delayed;
  logic                         delayed_written;
  logic signed [stet_pkg::SlopeW-1:0] slope;
  stet_pkg::fire_t              fire;
  logic                         prev_valid;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= '0;
      cfg_q.en_combined <= 1'b0;
      cfg_q.en_rise     <= 1'b0;
      cfg_q.en_fall     <= 1'b0;
      win_len_q         <= stet_pkg::WinReset;
    end else if (cfg_we) begin
      case (cfg_index_i)
        stet_pkg::RegThreshold:      cfg_q.threshold   <= $signed(cfg_data_i);
        stet_pkg::RegWindowLength:   win_len_q         <= cfg_data_i[stet_pkg::WinW-1:0];
        stet_pkg::RegEnableCombined: cfg_q.en_combined <= cfg_data_i[0];
        stet_pkg::RegEnableRise:     cfg_q.en_rise     <= cfg_data_i[0];
        stet_pkg::RegEnableFall:     cfg_q.en_fall     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  stet_delay_mem #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_delay_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (in_acc),
    .wr_data_i    (sample_i),
    .win_len_i    (win_len_q),
    .rd_data_o    (delayed),
    .rd_written_o (delayed_written)
  );

  stet_slope_unit u_slope_unit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (s1_adv),
    .sample_i          (s1_sample_q),
    .delayed_i         (delayed),
    .delayed_written_i (delayed_written),
    .cfg_i             (cfg_q),
    .slope_o           (slope),
    .fire_o            (fire),
    .prev_valid_o      (prev_valid)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
    end
    if (s1_adv) begin
      out_slope_q <= slope;
      out_fire_q  <= fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slope_o         = out_slope_q;
  assign combined_fire_o = out_fire_q.combined;
  assign rise_fire_o     = out_fire_q.rise;
  assign fall_fire_o     = out_fire_q.fall;

`ifndef ASSERT_OFF
  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("compare stage did not move into an empty output register");

  a_first_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !prev_valid |=> !combined_fire_o && !rise_fire_o && !fall_fire_o)
    else $error("first slope after reset raised a fire flag");

  a_zero_th_no_combined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (cfg_q.threshold == '0) |=> !combined_fire_o)
    else $error("combined fire with zero threshold");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |-> !in_acc && !s1_adv)
    else $error("pipeline advanced while output blocked");
`endif

endmodule
